// ----- rtl/core/gld_pkg.sv -----
// ----------------------------------------------------------------------------
// gld_pkg: shared types and constants of the GIF LZW decoder
// Field widths, register map, item kinds, controller states and the
// interlace pass tables.
// ----------------------------------------------------------------------------
package gld_pkg;

    // Fixed field widths
    localparam int CODE_W    = 12;   // widest LZW code
    localparam int NFC_W     = 13;   // next free code, holds the full table size
    localparam int BUF_W     = 20;   // bit buffer
    localparam int CNT_W     = 5;    // bits held in the buffer
    localparam int CW_W      = 4;    // current code width
    localparam int PIX_W     = 8;
    localparam int COUNT_W   = 17;
    localparam int KIND_W    = 2;
    localparam int ADDR_W    = 16;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;

    // Parameter defaults
    localparam int TABLE_SIZE_DEF    = 4096;
    localparam int MAX_CODE_BITS_DEF = 12;
    localparam int MAX_DIM_DEF       = 256;
    localparam int IMAGE_PIXELS_DEF  = 65536;

    // Register indexes
    localparam logic [2:0] REG_START_BITS   = 3'd0;
    localparam logic [2:0] REG_PALETTE_BITS = 3'd1;
    localparam logic [2:0] REG_WIDTH        = 3'd2;
    localparam logic [2:0] REG_HEIGHT       = 3'd3;
    localparam logic [2:0] REG_INTERLACE    = 3'd4;

    // Register reset values
    localparam logic [3:0] START_BITS_RST   = 4'd8;
    localparam logic [3:0] PALETTE_BITS_RST = 4'd8;
    localparam logic [8:0] WIDTH_RST        = 9'd256;
    localparam logic [8:0] HEIGHT_RST       = 9'd256;
    localparam logic       INTERLACE_RST    = 1'b0;

    // Decoder state after reset, derived from the register reset values
    localparam logic [CW_W-1:0]  CW_RST  = CW_W'(START_BITS_RST) + CW_W'(1);
    localparam logic [NFC_W-1:0] NFC_RST = (NFC_W'(1) << START_BITS_RST) + NFC_W'(2);

    typedef struct packed {
        logic [3:0] start_code_bits;
        logic [3:0] palette_bits;
        logic [8:0] image_width;
        logic [8:0] image_height;
        logic       interlace_mode;
    } cfg_regs_t;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_DATA  = 2'd1,
        KIND_READ  = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_DECODING = 2'd0,
        ST_END      = 2'd1,
        ST_ERROR    = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_EXTRACT,
        S_WALK_CHK,
        S_WALK_DAT,
        S_POP_RD,
        S_POP_WR,
        S_FINISH,
        S_DONE
    } state_t;

    // First row of each interlace pass
    function automatic logic [3:0] pass_start(input logic [1:0] p);
        logic [3:0] r;
        unique case (p)
            2'd0: r = 4'd0;
            2'd1: r = 4'd4;
            2'd2: r = 4'd2;
            2'd3: r = 4'd1;
        endcase
        return r;
    endfunction

    // Row step of each interlace pass
    function automatic logic [3:0] pass_step(input logic [1:0] p);
        logic [3:0] r;
        unique case (p)
            2'd0: r = 4'd8;
            2'd1: r = 4'd8;
            2'd2: r = 4'd4;
            2'd3: r = 4'd2;
        endcase
        return r;
    endfunction

    // Minimum code size saturated to 2..8
    function automatic logic [3:0] eff_start(input logic [3:0] v);
        logic [3:0] r;
        if (v < 4'd2) begin
            r = 4'd2;
        end else if (v > 4'd8) begin
            r = 4'd8;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Pixel mask from palette bits saturated to 1..8
    function automatic logic [7:0] eff_mask(input logic [3:0] v);
        logic [3:0] b;
        if (v < 4'd1) begin
            b = 4'd1;
        end else if (v > 4'd8) begin
            b = 4'd8;
        end else begin
            b = v;
        end
        return 8'((9'(1) << b) - 9'd1);
    endfunction

endpackage

// ----- rtl/core/gld_ram.sv -----
// ----------------------------------------------------------------------------
// gld_ram: simple dual-port synchronous RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write, and read with registered read data
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/gld_apb_regs.sv -----
// ----------------------------------------------------------------------------
// gld_apb_regs: configuration registers
// APB write and read access to the five decoder settings.
// ----------------------------------------------------------------------------
module gld_apb_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gld_pkg::PADDR_W-1:0]  paddr,
    input  logic [gld_pkg::PDATA_W-1:0]  pwdata,
    output logic [gld_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output gld_pkg::cfg_regs_t           cfg
);

    gld_pkg::cfg_regs_t cfg_reg;
    logic [2:0]         idx;
    logic               wr_en;

    assign idx    = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Register write on the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_code_bits <= gld_pkg::START_BITS_RST;
            cfg_reg.palette_bits    <= gld_pkg::PALETTE_BITS_RST;
            cfg_reg.image_width     <= gld_pkg::WIDTH_RST;
            cfg_reg.image_height    <= gld_pkg::HEIGHT_RST;
            cfg_reg.interlace_mode  <= gld_pkg::INTERLACE_RST;
        end else if (wr_en) begin
            unique case (idx)
                gld_pkg::REG_START_BITS:   cfg_reg.start_code_bits <= pwdata[3:0];
                gld_pkg::REG_PALETTE_BITS: cfg_reg.palette_bits    <= pwdata[3:0];
                gld_pkg::REG_WIDTH:        cfg_reg.image_width     <= pwdata[8:0];
                gld_pkg::REG_HEIGHT:       cfg_reg.image_height    <= pwdata[8:0];
                gld_pkg::REG_INTERLACE:    cfg_reg.interlace_mode  <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (idx)
            gld_pkg::REG_START_BITS:   prdata = 32'(cfg_reg.start_code_bits);
            gld_pkg::REG_PALETTE_BITS: prdata = 32'(cfg_reg.palette_bits);
            gld_pkg::REG_WIDTH:        prdata = 32'(cfg_reg.image_width);
            gld_pkg::REG_HEIGHT:       prdata = 32'(cfg_reg.image_height);
            gld_pkg::REG_INTERLACE:    prdata = 32'(cfg_reg.interlace_mode);
            default:                   prdata = '0;
        endcase
    end

endmodule

// ----- rtl/core/gif_lzw_decoder.sv -----
// ----------------------------------------------------------------------------
// gif_lzw_decoder: GIF LZW image decoder with an internal image store
// Unpacks LZW codes, expands them through the code table and a string
// stack, and writes pixels in plain or interlaced row order.
// ----------------------------------------------------------------------------
// Each input transfer yields exactly one result transfer. While decoding, a
// data byte is added to the bit buffer and every code that it completes is
// handled in turn: clear, end and first codes directly, the others by a
// chain walk that reads the prefix/suffix RAM once per entry, after which
// the string is popped from the stack RAM one pixel at a time. Only one
// item is in work at a time; the output register lets the next item in
// while a result waits. Configure only while the block is idle.
// ----------------------------------------------------------------------------
module gif_lzw_decoder #(
    parameter int TABLE_SIZE    = gld_pkg::TABLE_SIZE_DEF,
    parameter int MAX_CODE_BITS = gld_pkg::MAX_CODE_BITS_DEF,
    parameter int MAX_DIM       = gld_pkg::MAX_DIM_DEF,
    parameter int IMAGE_PIXELS  = gld_pkg::IMAGE_PIXELS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // data_byte [7:0], read_address [23:8]
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [gld_pkg::S_TDATA_W-1:0]  s_tdata,
    // kind [1:0]
    input  logic [gld_pkg::KIND_W-1:0]     s_tuser,
    // status [1:0], read_pixel [9:2], pixels_written [26:10], zeros above
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [gld_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [gld_pkg::PADDR_W-1:0]    paddr,
    input  logic [gld_pkg::PDATA_W-1:0]    pwdata,
    output logic [gld_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready
);

    localparam int TA_W   = $clog2(TABLE_SIZE);
    localparam int SA_W   = $clog2(IMAGE_PIXELS);
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int ROW_W  = $clog2(MAX_DIM + 9);
    localparam int PROD_W = 2 * DIM_W;
    localparam logic [31:0] TS_L  = 32'(TABLE_SIZE);
    localparam logic [31:0] MCB_L = 32'(MAX_CODE_BITS);
    localparam logic [31:0] MD_L  = 32'(MAX_DIM);
    localparam logic [31:0] IP_L  = 32'(IMAGE_PIXELS);

    localparam int CODE_W  = gld_pkg::CODE_W;
    localparam int NFC_W   = gld_pkg::NFC_W;
    localparam int BUF_W   = gld_pkg::BUF_W;
    localparam int CNT_W   = gld_pkg::CNT_W;
    localparam int CW_W    = gld_pkg::CW_W;
    localparam int PIX_W   = gld_pkg::PIX_W;
    localparam int COUNT_W = gld_pkg::COUNT_W;

    gld_pkg::cfg_regs_t cfg;

    gld_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Effective settings
    logic [3:0]       es;
    logic [8:0]       clr_code;
    logic [PIX_W-1:0] pmask;
    logic [DIM_W-1:0] eff_w;
    logic [DIM_W-1:0] eff_h;

    assign es         = gld_pkg::eff_start(cfg.start_code_bits);
    assign clr_code   = 9'(1) << es;
    assign pmask      = gld_pkg::eff_mask(cfg.palette_bits);

    always_comb begin
        if (cfg.image_width == 9'd0) begin
            eff_w = DIM_W'(1);
        end else if (32'(cfg.image_width) > MD_L) begin
            eff_w = DIM_W'(MAX_DIM);
        end else begin
            eff_w = DIM_W'(cfg.image_width);
        end
        if (cfg.image_height == 9'd0) begin
            eff_h = DIM_W'(1);
        end else if (32'(cfg.image_height) > MD_L) begin
            eff_h = DIM_W'(MAX_DIM);
        end else begin
            eff_h = DIM_W'(cfg.image_height);
        end
    end

    // Controller registers
    gld_pkg::state_t            state_reg, state_next;
    gld_pkg::kind_t             kind_reg, kind_next;
    logic [gld_pkg::ADDR_W-1:0] raddr_reg, raddr_next;
    gld_pkg::status_t           status_reg, status_next;
    logic [BUF_W-1:0]           buf_reg, buf_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [CW_W-1:0]            cw_reg, cw_next;
    logic [NFC_W-1:0]           nfc_reg, nfc_next;
    logic [CODE_W-1:0]          prev_reg, prev_next;
    logic                       prev_valid_reg, prev_valid_next;
    logic [PIX_W-1:0]           fp_reg, fp_next;
    logic [CODE_W-1:0]          cur_reg, cur_next;
    logic [CODE_W-1:0]          incode_reg, incode_next;
    logic [TA_W-1:0]            depth_reg, depth_next;
    logic                       m_tvalid_reg, m_tvalid_next;
    logic [1:0]                 m_status_reg, m_status_next;
    logic [PIX_W-1:0]           m_pixel_reg, m_pixel_next;
    logic [COUNT_W-1:0]         m_count_reg, m_count_next;

    // Pixel position registers
    logic [DIM_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [1:0]         pass_reg, pass_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    // Memory ports
    logic                 table_we, table_re;
    logic [19:0]          table_rdata;
    logic                 stack_we, stack_re;
    logic [TA_W-1:0]      stack_waddr;
    logic [PIX_W-1:0]     stack_wdata, stack_rdata;
    logic                 store_we, store_re;
    logic [SA_W-1:0]      store_waddr, store_raddr;
    logic [PIX_W-1:0]     store_wdata, store_rdata;

    // Pixel requests from the controller
    logic             pix_req, pix_clear;
    logic [PIX_W-1:0] pix_val;

    logic [CODE_W-1:0] cw_mask;
    logic [CODE_W-1:0] code;
    logic              read_in_range;

    assign cw_mask       = CODE_W'((NFC_W'(1) << cw_reg) - NFC_W'(1));
    assign code          = buf_reg[CODE_W-1:0] & cw_mask;
    assign read_in_range = 32'(raddr_reg) < IP_L;
    assign store_raddr   = SA_W'(32'(raddr_reg));

    gld_ram #(.WIDTH(CODE_W + PIX_W), .DEPTH(TABLE_SIZE)) u_table (
        .aclk  (aclk),
        .we    (table_we),
        .waddr (nfc_reg[TA_W-1:0]),
        .wdata ({prev_reg, fp_reg}),
        .re    (table_re),
        .raddr (cur_reg[TA_W-1:0]),
        .rdata (table_rdata)
    );

    gld_ram #(.WIDTH(PIX_W), .DEPTH(TABLE_SIZE)) u_stack (
        .aclk  (aclk),
        .we    (stack_we),
        .waddr (stack_waddr),
        .wdata (stack_wdata),
        .re    (stack_re),
        .raddr (depth_reg - TA_W'(1)),
        .rdata (stack_rdata)
    );

    gld_ram #(.WIDTH(PIX_W), .DEPTH(IMAGE_PIXELS)) u_store (
        .aclk  (aclk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (store_wdata),
        .re    (store_re),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    // Pixel placement: store address, count and row/column stepping
    always_comb begin
        logic              in_range;
        logic [PROD_W-1:0] prod;
        logic [31:0]       lin;
        logic [1:0]        p;
        logic [ROW_W-1:0]  r;

        col_next    = col_reg;
        row_next    = row_reg;
        pass_next   = pass_reg;
        count_next  = count_reg;
        store_we    = 1'b0;
        store_wdata = pix_val;

        in_range    = (32'(row_reg) < 32'(eff_h)) && (32'(col_reg) < 32'(eff_w));
        prod        = PROD_W'(row_reg[DIM_W-1:0]) * PROD_W'(eff_w);
        lin         = 32'(prod) + 32'(col_reg);
        store_waddr = lin[SA_W-1:0];
        p           = pass_reg;
        r           = row_reg + ROW_W'(gld_pkg::pass_step(pass_reg));

        if (pix_clear) begin
            col_next   = '0;
            row_next   = '0;
            pass_next  = '0;
            count_next = '0;
        end else if (pix_req && in_range) begin
            if (lin < IP_L) begin
                store_we = 1'b1;
                if (count_reg != {COUNT_W{1'b1}}) begin
                    count_next = count_reg + COUNT_W'(1);
                end
            end
            if (32'(col_reg) + 32'd1 < 32'(eff_w)) begin
                col_next = col_reg + DIM_W'(1);
            end else begin
                col_next = '0;
                if (!cfg.interlace_mode) begin
                    row_next = row_reg + ROW_W'(1);
                end else begin
                    // skip passes whose first row lies below the image
                    for (int i = 0; i < 3; i++) begin
                        if (32'(r) >= 32'(eff_h) && p != 2'd3) begin
                            p = p + 2'd1;
                            r = ROW_W'(gld_pkg::pass_start(p));
                        end
                    end
                    row_next  = r;
                    pass_next = p;
                end
            end
        end
    end

    assign s_tready = (state_reg == gld_pkg::S_IDLE);

    // Controller: next state and datapath control
    always_comb begin
        logic [NFC_W-1:0] nfc_grow;

        state_next      = state_reg;
        kind_next       = kind_reg;
        raddr_next      = raddr_reg;
        status_next     = status_reg;
        buf_next        = buf_reg;
        cnt_next        = cnt_reg;
        cw_next         = cw_reg;
        nfc_next        = nfc_reg;
        prev_next       = prev_reg;
        prev_valid_next = prev_valid_reg;
        fp_next         = fp_reg;
        cur_next        = cur_reg;
        incode_next     = incode_reg;
        depth_next      = depth_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_status_next   = m_status_reg;
        m_pixel_next    = m_pixel_reg;
        m_count_next    = m_count_reg;
        table_we        = 1'b0;
        table_re        = 1'b0;
        stack_we        = 1'b0;
        stack_re        = 1'b0;
        stack_waddr     = depth_reg;
        stack_wdata     = fp_reg;
        store_re        = 1'b0;
        pix_req         = 1'b0;
        pix_clear       = 1'b0;
        pix_val         = fp_reg;
        nfc_grow        = nfc_reg + NFC_W'(1);

        unique case (state_reg)
            gld_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    kind_next  = gld_pkg::kind_t'(s_tuser);
                    raddr_next = s_tdata[23:8];
                    unique case (gld_pkg::kind_t'(s_tuser))
                        gld_pkg::KIND_START: begin
                            // restart the image with the settings as they stand
                            buf_next        = '0;
                            cnt_next        = '0;
                            cw_next         = CW_W'(es) + CW_W'(1);
                            nfc_next        = NFC_W'(clr_code) + NFC_W'(2);
                            prev_valid_next = 1'b0;
                            prev_next       = '0;
                            fp_next         = '0;
                            status_next     = gld_pkg::ST_DECODING;
                            pix_clear       = 1'b1;
                            state_next      = gld_pkg::S_DONE;
                        end
                        gld_pkg::KIND_DATA: begin
                            if (status_reg == gld_pkg::ST_DECODING) begin
                                buf_next   = buf_reg | (BUF_W'(s_tdata[7:0]) << cnt_reg);
                                cnt_next   = cnt_reg + CNT_W'(8);
                                state_next = gld_pkg::S_EXTRACT;
                            end else begin
                                state_next = gld_pkg::S_DONE;
                            end
                        end
                        gld_pkg::KIND_READ: state_next = gld_pkg::S_READ;
                        gld_pkg::KIND_NONE: state_next = gld_pkg::S_DONE;
                    endcase
                end
            end
            gld_pkg::S_READ: begin
                store_re   = read_in_range;
                state_next = gld_pkg::S_DONE;
            end
            gld_pkg::S_EXTRACT: begin
                if (status_reg != gld_pkg::ST_DECODING || cnt_reg < CNT_W'(cw_reg)) begin
                    state_next = gld_pkg::S_DONE;
                end else begin
                    buf_next = buf_reg >> cw_reg;
                    cnt_next = cnt_reg - CNT_W'(cw_reg);
                    if (code == CODE_W'(clr_code) + CODE_W'(1)) begin
                        status_next = gld_pkg::ST_END;
                    end else if (code == CODE_W'(clr_code)) begin
                        cw_next         = CW_W'(es) + CW_W'(1);
                        nfc_next        = NFC_W'(clr_code) + NFC_W'(2);
                        prev_valid_next = 1'b0;
                        prev_next       = '0;
                    end else if (!prev_valid_reg) begin
                        // first code after a clear is a root code
                        fp_next         = code[PIX_W-1:0] & pmask;
                        pix_req         = 1'b1;
                        pix_val         = code[PIX_W-1:0] & pmask;
                        prev_next       = code;
                        prev_valid_next = 1'b1;
                    end else begin
                        incode_next = code;
                        if (NFC_W'(code) >= nfc_reg) begin
                            // code not yet in the table: string ends in the first pixel
                            stack_we    = 1'b1;
                            stack_waddr = '0;
                            stack_wdata = fp_reg;
                            depth_next  = TA_W'(1);
                            cur_next    = prev_reg;
                        end else begin
                            depth_next = '0;
                            cur_next   = code;
                        end
                        state_next = gld_pkg::S_WALK_CHK;
                    end
                end
            end
            gld_pkg::S_WALK_CHK: begin
                if (cur_reg > CODE_W'(pmask)) begin
                    if (32'(cur_reg) >= TS_L || 32'(depth_reg) >= TS_L - 32'd2) begin
                        status_next = gld_pkg::ST_ERROR;
                        state_next  = gld_pkg::S_EXTRACT;
                    end else begin
                        table_re   = 1'b1;
                        state_next = gld_pkg::S_WALK_DAT;
                    end
                end else begin
                    // root reached: emit it first, it heads the string
                    fp_next    = cur_reg[PIX_W-1:0] & pmask;
                    pix_req    = 1'b1;
                    pix_val    = cur_reg[PIX_W-1:0] & pmask;
                    state_next = gld_pkg::S_POP_RD;
                end
            end
            gld_pkg::S_WALK_DAT: begin
                stack_we    = 1'b1;
                stack_waddr = depth_reg;
                stack_wdata = table_rdata[PIX_W-1:0];
                depth_next  = depth_reg + TA_W'(1);
                cur_next    = table_rdata[CODE_W+PIX_W-1:PIX_W];
                state_next  = gld_pkg::S_WALK_CHK;
            end
            gld_pkg::S_POP_RD: begin
                if (depth_reg == '0) begin
                    state_next = gld_pkg::S_FINISH;
                end else begin
                    stack_re   = 1'b1;
                    depth_next = depth_reg - TA_W'(1);
                    state_next = gld_pkg::S_POP_WR;
                end
            end
            gld_pkg::S_POP_WR: begin
                pix_req    = 1'b1;
                pix_val    = stack_rdata;
                state_next = gld_pkg::S_POP_RD;
            end
            gld_pkg::S_FINISH: begin
                // add the new table entry and widen the code when it fills
                if (32'(nfc_reg) < TS_L) begin
                    table_we = 1'b1;
                    nfc_next = nfc_grow;
                    if (nfc_grow >= (NFC_W'(1) << cw_reg) && 32'(cw_reg) < MCB_L) begin
                        cw_next = cw_reg + CW_W'(1);
                    end
                end else if (nfc_reg >= (NFC_W'(1) << cw_reg) && 32'(cw_reg) < MCB_L) begin
                    cw_next = cw_reg + CW_W'(1);
                end
                prev_next  = incode_reg;
                state_next = gld_pkg::S_EXTRACT;
            end
            gld_pkg::S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = status_reg;
                    m_pixel_next  = (kind_reg == gld_pkg::KIND_READ && read_in_range)
                                    ? store_rdata : '0;
                    m_count_next  = count_reg;
                    state_next    = gld_pkg::S_IDLE;
                end
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= gld_pkg::S_IDLE;
            status_reg     <= gld_pkg::ST_DECODING;
            buf_reg        <= '0;
            cnt_reg        <= '0;
            cw_reg         <= gld_pkg::CW_RST;
            nfc_reg        <= gld_pkg::NFC_RST;
            prev_reg       <= '0;
            prev_valid_reg <= 1'b0;
            fp_reg         <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            pass_reg       <= '0;
            count_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            status_reg     <= status_next;
            buf_reg        <= buf_next;
            cnt_reg        <= cnt_next;
            cw_reg         <= cw_next;
            nfc_reg        <= nfc_next;
            prev_reg       <= prev_next;
            prev_valid_reg <= prev_valid_next;
            fp_reg         <= fp_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            pass_reg       <= pass_next;
            count_reg      <= count_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        kind_reg     <= kind_next;
        raddr_reg    <= raddr_next;
        cur_reg      <= cur_next;
        incode_reg   <= incode_next;
        depth_reg    <= depth_next;
        m_status_reg <= m_status_next;
        m_pixel_reg  <= m_pixel_next;
        m_count_reg  <= m_count_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, m_count_reg, m_pixel_reg, m_status_reg};

endmodule
